[src/lgs_pkg.sv]
// Shared types, constants and helpers for the life grid generation step block.
// No dependencies; every other file in src/ refers to it by scoped names.
package lgs_pkg;

    // Grid geometry (rows from 3 to 256, columns from 3 to 256)
    localparam int unsigned GRID_ROWS = 16;
    localparam int unsigned GRID_COLS = 16;

    // Field widths of one beat
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned COORD_W = 4;

    // Width that holds any coordinate or grid size for range compares
    localparam int unsigned IDX_W  = 9;
    // Column index width inside one row cell
    localparam int unsigned COL_IW = $clog2(GRID_COLS);
    // Neighbor count width (0..8)
    localparam int unsigned NBR_W  = 4;

    // Rule B3/S23
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

    // Command codes
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } state_t;

    // Sweep control broadcast to every row cell
    typedef struct packed {
        logic shift;      // advance one column this cycle
        logic first_col;  // current column is column 0
        logic last_col;   // current column is the last one
    } cell_ctl_t;

    // Old values a row cell hands to its neighbors around the current column
    typedef struct packed {
        logic prev;  // column to the left
        logic cur;   // current column
        logic nxt;   // column to the right
    } tap_t;

    // Column index inside a row from the input coordinate
    function automatic logic [COL_IW-1:0] col_index(input logic [COORD_W-1:0] col);
        logic [IDX_W-1:0] wide;
        wide = IDX_W'(col);
        return wide[COL_IW-1:0];
    endfunction

endpackage

[src/lgs_cell.sv]
// One row of the grid: a rotating row register that computes one new cell per sweep cycle.
// Depends on lgs_pkg (tap_t, cell_ctl_t, rule constants).
module lgs_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lgs_pkg::cell_ctl_t            ctl,
    input  lgs_pkg::tap_t                 up_tap,
    input  lgs_pkg::tap_t                 dn_tap,
    output lgs_pkg::tap_t                 own_tap,
    input  logic                          wr_en,
    input  logic [lgs_pkg::COL_IW-1:0]    col_idx,
    input  logic                          wr_val,
    output logic                          rd_bit
);

    logic [lgs_pkg::GRID_COLS-1:0] row_reg;
    logic [lgs_pkg::GRID_COLS-1:0] row_next;
    logic                          prev_reg;
    logic                          prev_next;
    logic [lgs_pkg::NBR_W-1:0]     nbr_cnt;
    logic                          new_bit;

    // Taps: bit 0 holds the current column's old value, bit 1 the next one's
    assign own_tap.prev = ctl.first_col ? 1'b0 : prev_reg;
    assign own_tap.cur  = row_reg[0];
    assign own_tap.nxt  = ctl.last_col ? 1'b0 : row_reg[1];

    // Neighbor count and rule
    assign nbr_cnt = lgs_pkg::NBR_W'(up_tap.prev) + lgs_pkg::NBR_W'(up_tap.cur)
                   + lgs_pkg::NBR_W'(up_tap.nxt)  + lgs_pkg::NBR_W'(dn_tap.prev)
                   + lgs_pkg::NBR_W'(dn_tap.cur)  + lgs_pkg::NBR_W'(dn_tap.nxt)
                   + lgs_pkg::NBR_W'(own_tap.prev) + lgs_pkg::NBR_W'(own_tap.nxt);
    assign new_bit = (nbr_cnt == lgs_pkg::BIRTH_COUNT)
                   || (own_tap.cur && (nbr_cnt == lgs_pkg::SURVIVE_COUNT));

    // Read port
    assign rd_bit = row_reg[col_idx];

    // Rotate during a sweep, new value enters at the top; single-bit writes otherwise
    always_comb
    begin
        row_next  = row_reg;
        prev_next = prev_reg;
        if (ctl.shift)
        begin
            row_next  = {new_bit, row_reg[lgs_pkg::GRID_COLS-1:1]};
            prev_next = row_reg[0];
        end
        else if (wr_en)
        begin
            row_next[col_idx] = wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    // Old left-hand value; only looked at after column 0
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
    end

endmodule

[src/lgs_ctrl.sv]
// Command controller: accepts beats, runs the column sweep, registers the result strobe.
// Depends on lgs_pkg (state_t, cell_ctl_t, command codes).
module lgs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lgs_pkg::KIND_W-1:0]    kind,
    input  logic                          rd_alive,
    output logic                          busy,
    output logic                          accept,
    output lgs_pkg::cell_ctl_t            ctl,
    output logic                          result_valid,
    output logic                          alive_out,
    output logic                          step_done
);

    lgs_pkg::state_t            state_reg;
    lgs_pkg::state_t            state_next;
    logic [lgs_pkg::COL_IW-1:0] col_cnt_reg;
    logic [lgs_pkg::COL_IW-1:0] col_cnt_next;
    logic                       last_col;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       alive_reg;
    logic                       alive_next;
    logic                       done_reg;
    logic                       done_next;

    assign accept   = start && !busy;
    assign last_col = (col_cnt_reg == lgs_pkg::COL_IW'(lgs_pkg::GRID_COLS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lgs_pkg::ST_IDLE:
            begin
                if (accept && (kind == lgs_pkg::KIND_STEP))
                    state_next = lgs_pkg::ST_STEP;
            end
            lgs_pkg::ST_STEP:
            begin
                if (last_col)
                    state_next = lgs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lgs_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        busy          = 1'b0;
        ctl.shift     = 1'b0;
        ctl.first_col = (col_cnt_reg == '0);
        ctl.last_col  = last_col;
        case (state_reg)
            lgs_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            lgs_pkg::ST_STEP:
            begin
                busy      = 1'b1;
                ctl.shift = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Column counter and result beat
    always_comb
    begin
        col_cnt_next = ctl.shift ? (last_col ? '0 : col_cnt_reg + 1'b1) : '0;
        valid_next   = 1'b0;
        alive_next   = 1'b0;
        done_next    = 1'b0;
        if (ctl.shift && last_col)
        begin
            valid_next = 1'b1;
            done_next  = 1'b1;
        end
        else if (accept && (kind == lgs_pkg::KIND_READ))
        begin
            valid_next = 1'b1;
            alive_next = rd_alive;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lgs_pkg::ST_IDLE;
            col_cnt_reg <= '0;
            valid_reg   <= 1'b0;
            alive_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_cnt_reg <= col_cnt_next;
            valid_reg   <= valid_next;
            alive_reg   <= alive_next;
            done_reg    <= done_next;
        end
    end

    assign result_valid = valid_reg;
    assign alive_out    = alive_reg;
    assign step_done    = done_reg;

endmodule

[src/life_grid_generation_step.sv]
// Top level of the Conway B3/S23 grid block: a chain of row cells plus a controller.
// Depends on lgs_pkg, lgs_cell and lgs_ctrl.
//
// A beat is taken at a rising edge with start high and busy low. A write gives no
// result. A read gives its result in the cycle after the beat. A step keeps busy
// high for the whole sweep: every row cell works on one column per cycle, so the
// sweep length is set by the column count, whatever the row count; its result shows
// in the cycle in which busy falls. Each result is shown for exactly one cycle with
// result_valid high and cannot be held off, so the receiver must take it then. Cells
// outside the grid read as dead; writes there and beats with the unused kind code are
// dropped. All cells are dead after reset.
module life_grid_generation_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lgs_pkg::KIND_W-1:0]    kind,
    input  logic [lgs_pkg::COORD_W-1:0]   row,
    input  logic [lgs_pkg::COORD_W-1:0]   col,
    input  logic                          alive_in,
    output logic                          result_valid,
    output logic                          alive_out,
    output logic                          step_done
);

    lgs_pkg::cell_ctl_t         ctl;
    lgs_pkg::tap_t              taps    [lgs_pkg::GRID_ROWS];
    logic [lgs_pkg::GRID_ROWS-1:0] row_hit;
    logic [lgs_pkg::GRID_ROWS-1:0] rd_bits;
    logic                       accept;
    logic                       col_ok;
    logic                       wr_cmd;
    logic                       rd_alive;
    logic [lgs_pkg::COL_IW-1:0] col_idx;

    // Address decode
    assign col_ok  = (lgs_pkg::IDX_W'(col) < lgs_pkg::IDX_W'(lgs_pkg::GRID_COLS));
    assign col_idx = lgs_pkg::col_index(col);
    assign wr_cmd  = accept && (kind == lgs_pkg::KIND_WRITE) && col_ok;

    // Chain of row cells; the rows above the top and below the bottom are dead
    for (genvar g = 0; g < lgs_pkg::GRID_ROWS; g++)
    begin : g_row
        lgs_pkg::tap_t up_tap;
        lgs_pkg::tap_t dn_tap;

        assign row_hit[g] = (lgs_pkg::IDX_W'(row) == lgs_pkg::IDX_W'(g));

        if (g == 0)
        begin : g_top
            assign up_tap = '0;
        end
        else
        begin : g_mid_up
            assign up_tap = taps[g-1];
        end

        if (g == lgs_pkg::GRID_ROWS - 1)
        begin : g_bot
            assign dn_tap = '0;
        end
        else
        begin : g_mid_dn
            assign dn_tap = taps[g+1];
        end

        lgs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .up_tap  (up_tap),
            .dn_tap  (dn_tap),
            .own_tap (taps[g]),
            .wr_en   (wr_cmd && row_hit[g]),
            .col_idx (col_idx),
            .wr_val  (alive_in),
            .rd_bit  (rd_bits[g])
        );
    end

    // Read select across rows
    assign rd_alive = col_ok && |(row_hit & rd_bits);

    lgs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .rd_alive     (rd_alive),
        .busy         (busy),
        .accept       (accept),
        .ctl          (ctl),
        .result_valid (result_valid),
        .alive_out    (alive_out),
        .step_done    (step_done)
    );

endmodule

[src/lgs_checker.sv]
// Port-level checks for life_grid_generation_step, attached by bind.
// Depends on lgs_pkg (command codes) and the top level's ports.
module lgs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [lgs_pkg::KIND_W-1:0]    kind,
    input  logic                          result_valid,
    input  logic                          alive_out,
    input  logic                          step_done
);

    // Result fields stay quiet between beats
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> (!alive_out && !step_done))
        else $error("result fields set without a result beat");

    // A step beat makes the block busy next cycle
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == lgs_pkg::KIND_STEP)) |=> busy)
        else $error("step accepted but sweep not started");

    // A read beat answers in the next cycle
    a_read_ans: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == lgs_pkg::KIND_READ)) |=> (result_valid && !step_done))
        else $error("read accepted but no read result");

    // End of a sweep brings the step result
    a_step_ans: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && step_done && !alive_out))
        else $error("sweep ended without a step result");

    // A write gives no result
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == lgs_pkg::KIND_WRITE)) |=> !result_valid)
        else $error("write produced a result");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .result_valid (result_valid),
    .alive_out    (alive_out),
    .step_done    (step_done)
);
